// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/obsfb_pkg.sv =====
`timescale 1ns / 1ps

package obsfb_pkg;

    localparam int WORD_W  = 32;
    localparam int PROD_W  = 2 * WORD_W;
    localparam int FRAC_W  = 16;
    localparam int ACC_W   = WORD_W + 3;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = 4;

    // register indexes
    localparam logic [IDX_W-1:0] REG_FEEDBACK = 3'd0;
    localparam logic [IDX_W-1:0] REG_OBSERVER = 3'd1;
    localparam logic [IDX_W-1:0] REG_A_TOP    = 3'd2;
    localparam logic [IDX_W-1:0] REG_A_BOTTOM = 3'd3;
    localparam logic [IDX_W-1:0] REG_INPUT    = 3'd4;
    localparam logic [IDX_W-1:0] REG_OUTPUT   = 3'd5;
    localparam logic [IDX_W-1:0] REG_LIMITS   = 3'd6;

    // multiply schedule
    localparam logic [CNT_W-1:0] OP_K0R   = 4'd0;
    localparam logic [CNT_W-1:0] OP_K1X1  = 4'd1;
    localparam logic [CNT_W-1:0] OP_C1X1  = 4'd2;
    localparam logic [CNT_W-1:0] OP_C2X2  = 4'd3;
    localparam logic [CNT_W-1:0] OP_A11X1 = 4'd4;
    localparam logic [CNT_W-1:0] OP_A12X2 = 4'd5;
    localparam logic [CNT_W-1:0] OP_B1U   = 4'd6;
    localparam logic [CNT_W-1:0] OP_LE1   = 4'd7;
    localparam logic [CNT_W-1:0] OP_A21X1 = 4'd8;
    localparam logic [CNT_W-1:0] OP_A22X2 = 4'd9;
    localparam logic [CNT_W-1:0] OP_B2U   = 4'd10;
    localparam logic [CNT_W-1:0] OP_LE2   = 4'd11;
    localparam logic [CNT_W-1:0] NUM_OPS  = 4'd12;

    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_MIN  = 2'd1;
    localparam logic [1:0] CLAMP_MAX  = 2'd2;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef struct packed {
        t_word k0;
        t_word k1;
        t_word l;
        t_word a11;
        t_word a12;
        t_word a21;
        t_word a22;
        t_word b1;
        t_word b2;
        t_word c1;
        t_word c2;
        t_word umax;
        t_word umin;
    } t_cfg;

    typedef struct packed {
        t_word      drive_out;
        t_word      drive_raw;
        logic [1:0] clamp_state;
    } t_res;

    function automatic t_word sat_word(input t_acc v);
        t_word r;
        if (v[ACC_W-1:WORD_W-1] == {(ACC_W-WORD_W+1){v[ACC_W-1]}}) begin
            r = v[WORD_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(WORD_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic t_acc ext_word(input t_word w);
        return {{(ACC_W-WORD_W){w[WORD_W-1]}}, w};
    endfunction

endpackage

// ===== rtl/observer_state_feedback_step.sv =====
`timescale 1ns / 1ps
// Second-order state observer with state feedback in signed Q16.16. Each item
// (measured, setpoint) yields one result: the clamped drive, the raw drive and
// a clamp code, after which the internal estimate advances. All twelve products
// of a step go through one registered 32x32 multiplier, one product per cycle.
// An item occupies the block from acceptance until its result is loaded into
// the output register, which waits while the previous result has not been
// taken; no new item is accepted before the block is idle again. Register
// writes are taken in any cycle and must only be made while the block is idle.

`include "assert_macros.svh"

module observer_state_feedback_step import obsfb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [WORD_W-1:0] i_measured,
    input  logic signed [WORD_W-1:0] i_setpoint,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [WORD_W-1:0] o_drive_out,
    output logic signed [WORD_W-1:0] o_drive_raw,
    output logic [1:0]              o_clamp_state
);

    t_cfg r_cfg;
    t_res r_out;
    logic r_out_valid;

    logic core_idle;
    logic core_done;
    logic out_free;
    t_res core_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = core_idle;
    assign out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FEEDBACK: begin
                    r_cfg.k0 <= i_cfg_data[63:32];
                    r_cfg.k1 <= i_cfg_data[31:0];
                end
                REG_OBSERVER: r_cfg.l <= i_cfg_data[31:0];
                REG_A_TOP: begin
                    r_cfg.a11 <= i_cfg_data[63:32];
                    r_cfg.a12 <= i_cfg_data[31:0];
                end
                REG_A_BOTTOM: begin
                    r_cfg.a21 <= i_cfg_data[63:32];
                    r_cfg.a22 <= i_cfg_data[31:0];
                end
                REG_INPUT: begin
                    r_cfg.b1 <= i_cfg_data[63:32];
                    r_cfg.b2 <= i_cfg_data[31:0];
                end
                REG_OUTPUT: begin
                    r_cfg.c1 <= i_cfg_data[63:32];
                    r_cfg.c2 <= i_cfg_data[31:0];
                end
                REG_LIMITS: begin
                    r_cfg.umax <= i_cfg_data[63:32];
                    r_cfg.umin <= i_cfg_data[31:0];
                end
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    obsfb_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_start    (i_in_valid && core_idle),
        .i_y        (i_measured),
        .i_r        (i_setpoint),
        .i_out_free (out_free),
        .o_idle     (core_idle),
        .o_done     (core_done),
        .o_res      (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (core_done) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_out   = r_out.drive_out;
    assign o_drive_raw   = r_out.drive_raw;
    assign o_clamp_state = r_out.clamp_state;

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `ASSERT_IMPL(a_clamp_code, i_clk, i_rst_n, o_out_valid, o_clamp_state != 2'd3)
    `ASSERT_IMPL(a_unclamped_pass, i_clk, i_rst_n,
        o_out_valid && (o_clamp_state == CLAMP_NONE), o_drive_out == o_drive_raw)
    `ASSERT_IMPL(a_done_needs_room, i_clk, i_rst_n, core_done, out_free && !core_idle)

endmodule

// ===== rtl/obsfb_mul.sv =====
`timescale 1ns / 1ps

module obsfb_mul import obsfb_pkg::*; (
    input  logic  i_clk,
    input  t_word i_a,
    input  t_word i_b,
    output t_word o_q
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // floor shift by FRAC_W, saturate to a word
    always_comb begin
        if (r_prod[PROD_W-1:FRAC_W+WORD_W-1] ==
            {(PROD_W-FRAC_W-WORD_W+1){r_prod[PROD_W-1]}}) begin
            o_q = r_prod[FRAC_W+WORD_W-1:FRAC_W];
        end else if (r_prod[PROD_W-1]) begin
            o_q = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            o_q = {1'b0, {(WORD_W-1){1'b1}}};
        end
    end

endmodule

// ===== rtl/obsfb_core.sv =====
`timescale 1ns / 1ps

module obsfb_core import obsfb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_start,
    input  t_word i_y,
    input  t_word i_r,
    input  logic  i_out_free,
    output logic  o_idle,
    output logic  o_done,
    output t_res  o_res
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_y, r_r;
    t_word            r_x1, r_x2, r_x1n, r_x2n;
    t_word            r_u, r_e1, r_e2;
    t_acc             r_acc;

    t_acc             n_acc;
    t_word            n_u, n_e1, n_e2, n_x1n, n_x2n;
    t_word            mul_a, mul_b, mul_q;
    logic [CNT_W-1:0] ret_op;
    t_acc             q_ext;

    obsfb_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_q   (mul_q)
    );

    // operand select for the op issued this cycle
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_cnt)
            OP_K0R:   begin mul_a = i_cfg.k0;  mul_b = r_r;  end
            OP_K1X1:  begin mul_a = i_cfg.k1;  mul_b = r_x1; end
            OP_C1X1:  begin mul_a = i_cfg.c1;  mul_b = r_x1; end
            OP_C2X2:  begin mul_a = i_cfg.c2;  mul_b = r_x2; end
            OP_A11X1: begin mul_a = i_cfg.a11; mul_b = r_x1; end
            OP_A12X2: begin mul_a = i_cfg.a12; mul_b = r_x2; end
            OP_B1U:   begin mul_a = i_cfg.b1;  mul_b = r_u;  end
            OP_LE1:   begin mul_a = i_cfg.l;   mul_b = r_e1; end
            OP_A21X1: begin mul_a = i_cfg.a21; mul_b = r_x1; end
            OP_A22X2: begin mul_a = i_cfg.a22; mul_b = r_x2; end
            OP_B2U:   begin mul_a = i_cfg.b2;  mul_b = r_u;  end
            OP_LE2:   begin mul_a = i_cfg.l;   mul_b = r_e2; end
            default:  begin mul_a = '0;        mul_b = '0;   end
        endcase
    end

    // retire the product issued last cycle
    always_comb begin
        ret_op = r_cnt - 4'd1;
        q_ext  = ext_word(mul_q);
        n_acc  = r_acc;
        n_u    = r_u;
        n_e1   = r_e1;
        n_e2   = r_e2;
        n_x1n  = r_x1n;
        n_x2n  = r_x2n;
        case (ret_op)
            OP_K0R:   n_acc = q_ext;
            OP_K1X1:  n_u   = sat_word(r_acc - q_ext);
            OP_C1X1:  n_e1  = sat_word(ext_word(r_y) - q_ext);
            OP_C2X2:  n_e2  = sat_word(ext_word(r_y) - q_ext);
            OP_A11X1: n_acc = q_ext;
            OP_A12X2: n_acc = r_acc + q_ext;
            OP_B1U:   n_acc = r_acc + q_ext;
            OP_LE1:   n_x1n = sat_word(r_acc + q_ext);
            OP_A21X1: n_acc = q_ext;
            OP_A22X2: n_acc = r_acc + q_ext;
            OP_B2U:   n_acc = r_acc + q_ext;
            OP_LE2:   n_x2n = sat_word(r_acc + q_ext);
            default:  n_acc = r_acc;
        endcase
    end

    // minimum test first, maximum test wins
    always_comb begin
        o_res.drive_raw   = r_u;
        o_res.drive_out   = r_u;
        o_res.clamp_state = CLAMP_NONE;
        if (r_u < i_cfg.umin) begin
            o_res.drive_out   = i_cfg.umin;
            o_res.clamp_state = CLAMP_MIN;
        end
        if (r_u > i_cfg.umax) begin
            o_res.drive_out   = i_cfg.umax;
            o_res.clamp_state = CLAMP_MAX;
        end
    end

    assign o_idle = (r_state == ST_IDLE);
    assign o_done = (r_state == ST_DONE) && i_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_x1    <= '0;
            r_x2    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (i_start) begin
                        r_y     <= i_y;
                        r_r     <= i_r;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt != '0) begin
                        r_acc <= n_acc;
                        r_u   <= n_u;
                        r_e1  <= n_e1;
                        r_e2  <= n_e2;
                        r_x1n <= n_x1n;
                        r_x2n <= n_x2n;
                    end
                    if (r_cnt == NUM_OPS) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    r_cnt <= '0;
                    if (i_out_free) begin
                        r_x1    <= r_x1n;
                        r_x2    <= r_x2n;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/tb_observer_state_feedback_step.sv =====
`timescale 1ns / 1ps

module tb_observer_state_feedback_step;
    import obsfb_pkg::*;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam t_word W_MAX   = 32'sh7fffffff;
    localparam t_word W_MIN   = 32'sh80000000;
    localparam t_word ONE     = 32'sh00010000;
    localparam t_word HALF    = 32'sh00008000;
    localparam t_word QUARTER = 32'sh00004000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [IDX_W-1:0]         i_cfg_index;
    logic [CFG_W-1:0]         i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic signed [WORD_W-1:0] i_measured;
    logic signed [WORD_W-1:0] i_setpoint;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [WORD_W-1:0] o_drive_out;
    logic signed [WORD_W-1:0] o_drive_raw;
    logic [1:0]               o_clamp_state;

    // model state
    logic [CFG_W-1:0] cfg_word [0:6];
    t_word            obs_x1;
    t_word            obs_x2;
    t_res             drive_expect_q [$];
    t_res             drive_want;
    int               err_cnt = 0;

    // stimulus control
    int       burst_left = 0;
    bit       idle_on = 1'b1;
    t_rx_mode recv_mode = RX_ALWAYS;
    int       hold_left = 0;

    observer_state_feedback_step u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_measured    (i_measured),
        .i_setpoint    (i_setpoint),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_drive_out   (o_drive_out),
        .o_drive_raw   (o_drive_raw),
        .o_clamp_state (o_clamp_state)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_word clip_word(input longint v);
        if (v > longint'(W_MAX)) begin
            return W_MAX;
        end else if (v < longint'(W_MIN)) begin
            return W_MIN;
        end
        return t_word'(v);
    endfunction

    // Q16.16 product, floor shift, then clip
    function automatic longint qprod(input t_word a, input t_word b);
        longint p;
        p = longint'(a) * longint'(b);
        return longint'(clip_word(p >>> FRAC_W));
    endfunction

    function automatic void advance_observer(input t_word y, input t_word r);
        t_word      k0, k1, lg, umax, umin, u, us, e1, e2, x1, x2;
        logic [1:0] flag;
        t_res       res;
        x1   = obs_x1;
        x2   = obs_x2;
        k0   = cfg_word[REG_FEEDBACK][63:32];
        k1   = cfg_word[REG_FEEDBACK][31:0];
        lg   = cfg_word[REG_OBSERVER][31:0];
        umax = cfg_word[REG_LIMITS][63:32];
        umin = cfg_word[REG_LIMITS][31:0];

        u    = clip_word(qprod(k0, r) - qprod(k1, x1));
        us   = u;
        flag = CLAMP_NONE;
        // minimum first, maximum wins on inverted limits
        if (u < umin) begin
            us   = umin;
            flag = CLAMP_MIN;
        end
        if (u > umax) begin
            us   = umax;
            flag = CLAMP_MAX;
        end

        e1 = clip_word(longint'(y) - qprod(cfg_word[REG_OUTPUT][63:32], x1));
        e2 = clip_word(longint'(y) - qprod(cfg_word[REG_OUTPUT][31:0], x2));
        obs_x1 = clip_word(qprod(cfg_word[REG_A_TOP][63:32], x1)
                           + qprod(cfg_word[REG_A_TOP][31:0], x2)
                           + qprod(cfg_word[REG_INPUT][63:32], u) + qprod(lg, e1));
        obs_x2 = clip_word(qprod(cfg_word[REG_A_BOTTOM][63:32], x1)
                           + qprod(cfg_word[REG_A_BOTTOM][31:0], x2)
                           + qprod(cfg_word[REG_INPUT][31:0], u) + qprod(lg, e2));

        res.drive_out   = us;
        res.drive_raw   = u;
        res.clamp_state = flag;
        drive_expect_q.push_back(res);
    endfunction

    function automatic t_word rand_q(input int unsigned mag);
        int v;
        v = int'($urandom_range(0, 2 * mag)) - int'(mag);
        return t_word'(v);
    endfunction

    function automatic t_word rand_sample();
        if ($urandom_range(0, 7) == 0) begin
            return t_word'($urandom);
        end
        return rand_q(4 * 65536);
    endfunction

    function automatic t_cfg rand_cfg(input bit wide);
        t_cfg c;
        if (wide) begin
            c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            c.k0   = rand_q(2 * 65536);
            c.k1   = rand_q(65536);
            c.l    = rand_q(32768);
            c.a11  = rand_q(29491);
            c.a12  = rand_q(29491);
            c.a21  = rand_q(29491);
            c.a22  = rand_q(29491);
            c.b1   = rand_q(32768);
            c.b2   = rand_q(32768);
            c.c1   = rand_q(65536);
            c.c2   = rand_q(65536);
            c.umax = t_word'($urandom_range(0, 6 * 65536));
            c.umin = -t_word'($urandom_range(0, 6 * 65536));
        end
        return c;
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx <= REG_LIMITS) begin
            cfg_word[idx] = data;
        end
        @(negedge i_clk);
    endtask

    task automatic load_config(input t_cfg c);
        write_reg(REG_FEEDBACK, {c.k0, c.k1});
        write_reg(REG_OBSERVER, {t_word'($urandom), c.l});
        write_reg(REG_A_TOP, {c.a11, c.a12});
        write_reg(REG_A_BOTTOM, {c.a21, c.a22});
        write_reg(REG_INPUT, {c.b1, c.b2});
        write_reg(REG_OUTPUT, {c.c1, c.c2});
        write_reg(REG_LIMITS, {c.umax, c.umin});
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_sample(input t_word y, input t_word r);
        i_in_valid <= 1'b1;
        i_measured <= y;
        i_setpoint <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        advance_observer(y, r);
        @(negedge i_clk);
        if (idle_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // drain all results, then give the last update time to land
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (drive_expect_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_reset_state();
        send_sample(W_MAX, W_MAX);
        send_sample(W_MIN, W_MIN);
        send_sample(W_MIN, ONE);
    endtask

    task automatic test_directed();
        t_cfg c;
        c = '{k0: ONE, k1: HALF, l: QUARTER, a11: HALF, a12: QUARTER, a21: -QUARTER,
              a22: HALF, b1: ONE, b2: HALF, c1: ONE, c2: -ONE, umax: 2 * ONE,
              umin: -2 * ONE};
        settle_block();
        load_config(c);
        send_sample('0, '0);
        send_sample(ONE, ONE);
        send_sample('0, 3 * ONE);
        send_sample('0, -3 * ONE);
        send_sample(-1, -1);
        send_sample(W_MAX, W_MAX);
        send_sample(W_MIN, W_MIN);
        send_sample(W_MIN, W_MAX);

        // inverted limits
        settle_block();
        c.umax = -ONE;
        c.umin = ONE;
        load_config(c);
        send_sample('0, '0);
        send_sample('0, -3 * ONE);
        send_sample('0, 3 * ONE);

        // bad index must leave everything alone
        settle_block();
        write_reg(REG_UNUSED, {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        send_sample(ONE, -ONE);
        send_sample(HALF, 2 * ONE);

        // saturation everywhere
        settle_block();
        load_config({13{W_MAX}});
        send_sample(W_MAX, W_MAX);
        send_sample(W_MIN, W_MIN);
        send_sample(W_MAX, W_MIN);
        settle_block();
        load_config({13{W_MIN}});
        send_sample(W_MIN, W_MAX);
        send_sample(W_MAX, W_MIN);
        send_sample('0, '0);
    endtask

    task automatic test_random_tracking();
        t_cfg c;
        for (int ph = 0; ph < 7; ph++) begin
            settle_block();
            c = rand_cfg(1'b0);
            load_config(c);
            idle_on   = (ph != 0) && (ph != 5);
            recv_mode = (ph == 0) ? RX_ALWAYS : t_rx_mode'(ph % 4);
            for (int n = 0; n < 190; n++) begin
                send_sample(rand_sample(), rand_sample());
            end
        end
    endtask

    task automatic test_random_wide();
        for (int ph = 0; ph < 4; ph++) begin
            settle_block();
            load_config(rand_cfg(1'b1));
            idle_on   = 1'b1;
            recv_mode = t_rx_mode'((ph + 1) % 4);
            for (int n = 0; n < 80; n++) begin
                send_sample(t_word'($urandom), t_word'($urandom));
            end
        end
    endtask

    task automatic test_output_hold();
        settle_block();
        load_config(rand_cfg(1'b0));
        idle_on   = 1'b0;
        recv_mode = RX_COIN;
        hold_left = HOLD_CYCLES;
        for (int n = 0; n < 40; n++) begin
            send_sample(rand_sample(), rand_sample());
        end
    endtask

    initial begin
        int unsigned tick;
        tick        = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (recv_mode)
                    RX_ALWAYS: i_out_ready <= 1'b1;
                    RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_out_ready <= (tick % 11) >= 4;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (drive_expect_q.size() == 0) begin
                $display("%0t unexpected item: drive_out %0d drive_raw %0d clamp %0d",
                         $time, o_drive_out, o_drive_raw, o_clamp_state);
                err_cnt++;
            end else begin
                drive_want = drive_expect_q.pop_front();
                if (o_drive_out !== drive_want.drive_out) begin
                    $display("%0t drive_out mismatch: expected %0d actual %0d",
                             $time, drive_want.drive_out, o_drive_out);
                    err_cnt++;
                end
                if (o_drive_raw !== drive_want.drive_raw) begin
                    $display("%0t drive_raw mismatch: expected %0d actual %0d",
                             $time, drive_want.drive_raw, o_drive_raw);
                    err_cnt++;
                end
                if (o_clamp_state !== drive_want.clamp_state) begin
                    $display("%0t clamp_state mismatch: expected %0d actual %0d",
                             $time, drive_want.clamp_state, o_clamp_state);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_FEEDBACK;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_measured  = '0;
        i_setpoint  = '0;
        for (int i = 0; i <= REG_LIMITS; i++) begin
            cfg_word[i] = '0;
        end
        obs_x1 = '0;
        obs_x2 = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_directed();
        test_random_tracking();
        test_random_wide();
        test_output_hold();
        settle_block();

        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/obsfb_pkg.sv
rtl/obsfb_mul.sv
rtl/obsfb_core.sv
rtl/observer_state_feedback_step.sv
tb/tb_observer_state_feedback_step.sv
